// ===== rtl/ifcb_pkg.sv =====
// shared types and constants for the int/float compare bitmask packer
package ifcb_pkg;

   // compare operator codes
   localparam logic [1:0] OP_EQ = 2'd0;
   localparam logic [1:0] OP_LT = 2'd1;
   localparam logic [1:0] OP_GT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_ORDER = 2'd1;
   localparam logic [1:0] REG_OP    = 2'd2;

   // integer width codes
   localparam logic [1:0] W8  = 2'd0;
   localparam logic [1:0] W16 = 2'd1;
   localparam logic [1:0] W32 = 2'd2;
   localparam logic [1:0] W64 = 2'd3;

   // configuration settings
   typedef struct packed {
      logic [1:0] width_code;
      logic       int_on_left;
      logic [1:0] op;
   } cfg_type;

   // compare outcome of one item, passed to the packer
   typedef struct packed {
      logic hit;
      logic last;
   } bit_type;

endpackage

// ===== rtl/ifcb_if.sv =====
// valid/ready channel interfaces for items and configuration writes
interface ifcb_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] int_elem;
   logic [63:0] float_bits;
   logic        last_item;
   modport source (output valid, int_elem, float_bits, last_item, input ready);
   modport sink (input valid, int_elem, float_bits, last_item, output ready);
   modport monitor (input valid, ready, int_elem, float_bits, last_item);
endinterface

interface ifcb_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] mask_word;
   logic [6:0]  valid_bits;
   logic        final_word;
   modport source (output valid, mask_word, valid_bits, final_word, input ready);
   modport sink (input valid, mask_word, valid_bits, final_word, output ready);
   modport monitor (input valid, ready, mask_word, valid_bits, final_word);
endinterface

interface ifcb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/ifcb_cmp.sv =====
// integer to double conversion and compare against a double, combinational
module ifcb_cmp (
   input  logic [63:0]      int_elem,
   input  logic [63:0]      float_bits,
   input  ifcb_pkg::cfg_type cfg,
   output logic             hit
);
   import ifcb_pkg::*;

   logic [63:0] sx;
   logic        sgn;
   logic [63:0] mag;
   logic [5:0]  p;
   logic [63:0] norm;
   logic [53:0] keep;
   logic        rnd;
   logic        sticky;
   logic [10:0] iexp;
   logic [51:0] ifrac;
   logic        izero;
   logic        fnan;
   logic        a_lt_b;
   logic        a_eq_b;
   logic        lt;
   logic        eq;
   logic [63:0] ib;
   logic        fsgn;
   logic [62:0] fmag;
   logic        fzero;

   // sign extend from configured width
   always_comb begin
      unique case (cfg.width_code)
         W8:      sx = {{56{int_elem[7]}}, int_elem[7:0]};
         W16:     sx = {{48{int_elem[15]}}, int_elem[15:0]};
         W32:     sx = {{32{int_elem[31]}}, int_elem[31:0]};
         default: sx = int_elem;
      endcase
   end

   // magnitude, leading one, normalize, round to nearest even
   always_comb begin
      sgn  = sx[63];
      mag  = sgn ? (64'd0 - sx) : sx;
      p    = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) p = 6'(i);
      end
      norm   = mag << (6'd63 - p);
      sticky = |norm[9:0];
      rnd    = norm[10] && (sticky || norm[11]);
      keep   = {1'b0, norm[63:11]} + 54'(rnd);
      izero  = (mag == 64'd0);
      if (keep[53]) begin
         iexp  = 11'(p) + 11'd1024;
         ifrac = keep[52:1];
      end else begin
         iexp  = 11'(p) + 11'd1023;
         ifrac = keep[51:0];
      end
      ib = izero ? 64'd0 : {sgn, iexp, ifrac};
   end

   // ordered compare of ib against float_bits
   always_comb begin
      fsgn  = float_bits[63];
      fmag  = float_bits[62:0];
      fnan  = (float_bits[62:52] == 11'h7ff) && (float_bits[51:0] != 52'd0);
      fzero = (fmag == 63'd0);
      // integer side is never nan; signed zeros compare equal
      eq = (izero && fzero) || (ib == float_bits);
      if (izero && fzero)
         lt = 1'b0;
      else if (ib[63] != fsgn)
         lt = ib[63];
      else if (ib[63])
         lt = ib[62:0] > fmag;
      else
         lt = ib[62:0] < fmag;
      // orient operands
      a_eq_b = eq;
      a_lt_b = cfg.int_on_left ? lt : (!lt && !eq);
      if (fnan)
         hit = 1'b0;
      else begin
         unique case (cfg.op)
            OP_EQ:   hit = a_eq_b;
            OP_LT:   hit = a_lt_b;
            default: hit = !a_lt_b && !a_eq_b;
         endcase
      end
   end
endmodule

// ===== rtl/ifcb_pack.sv =====
// bit packer: gathers compare bits into words and holds the output register
module ifcb_pack #(
   parameter int WORD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ifcb_pkg::bit_type in_bit,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [63:0]       out_word,
   output logic [6:0]        out_count,
   output logic              out_final
);
   import ifcb_pkg::*;

   localparam int PW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] part_ff, part_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 ov_ff, ov_in;
   logic [63:0]          word_ff, word_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 fin_ff, fin_in;
   logic [WORD_BITS-1:0] merged;
   logic                 full;
   logic                 take;

   // the output register frees whenever it is taken
   assign in_ready = !ov_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      merged = part_ff;
      merged[pos_ff] = in_bit.hit;
      full    = (pos_ff == PW'(WORD_BITS - 1));
      part_in = part_ff;
      pos_in  = pos_ff;
      ov_in   = ov_ff && !out_ready;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      fin_in  = fin_ff;
      if (take) begin
         if (full || in_bit.last) begin
            part_in = '0;
            pos_in  = '0;
            ov_in   = 1'b1;
            word_in = 64'(merged);
            cnt_in  = 7'(pos_ff) + 7'd1;
            fin_in  = in_bit.last;
         end else begin
            part_in = merged;
            pos_in  = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         pos_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         part_ff <= part_in;
         pos_ff  <= pos_in;
         ov_ff   <= ov_in;
      end
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      fin_ff  <= fin_in;
   end

   assign out_valid = ov_ff;
   assign out_word  = word_ff;
   assign out_count = cnt_ff;
   assign out_final = fin_ff;
endmodule

// ===== rtl/int_float_compare_bitmask_packer.sv =====
// top level of the int/float compare bitmask packer
// Usage:
//   req channel carries one element pair per item: int_elem (low bytes per
//   the width register, sign extended), float_bits (binary64) and last_item.
//   rsp channel carries packed words: mask_word (item k of the word in bit k),
//   valid_bits (1..WORD_BITS) and final_word.
//   csr channel writes index 0 width code, 1 operand order, 2 operator;
//   it is always ready and should only be used while the block is idle.
// Timing:
//   an accepted item is registered, then converted and compared combinationally, and its bit enters
//   the packer when the packer is ready; a completed word is held in the packer's
//   output register and presented on rsp. One item per cycle is sustained
//   while rsp does not stall, set by the single input register feeding the
//   compare and the packer's output register.
// Reset clears the registers to width 8 bytes, integer on the left, equal,
//   and empties the partial word.
// When rsp stalls with a word pending, the input register and then req hold.
module int_float_compare_bitmask_packer #(
   parameter int WORD_BITS = 64
) (
   input  logic clock,
   input  logic reset,
   ifcb_req_if.sink   req,
   ifcb_rsp_if.source rsp,
   ifcb_csr_if.sink   csr
);
   import ifcb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        iv_ff, iv_in;
   logic [63:0] int_ff, int_in;
   logic [63:0] flt_ff, flt_in;
   logic        last_ff, last_in;
   logic        hit;
   logic        pk_ready;
   bit_type     pk_bit;

   // configuration registers
   assign csr.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_WIDTH: cfg_in.width_code  = csr.data[1:0];
            REG_ORDER: cfg_in.int_on_left = csr.data[0];
            REG_OP:    cfg_in.op          = csr.data[1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   // input register
   assign req.ready = !iv_ff || pk_ready;
   always_comb begin
      iv_in   = iv_ff && !pk_ready;
      int_in  = int_ff;
      flt_in  = flt_ff;
      last_in = last_ff;
      if (req.valid && req.ready) begin
         iv_in   = 1'b1;
         int_in  = req.int_elem;
         flt_in  = req.float_bits;
         last_in = req.last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width_code: W64, int_on_left: 1'b1, op: OP_EQ};
         iv_ff  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         iv_ff  <= iv_in;
      end
      int_ff  <= int_in;
      flt_ff  <= flt_in;
      last_ff <= last_in;
   end

   ifcb_cmp u_cmp (
      .int_elem   (int_ff),
      .float_bits (flt_ff),
      .cfg        (cfg_ff),
      .hit        (hit)
   );

   assign pk_bit = '{hit: hit, last: last_ff};

   ifcb_pack #(.WORD_BITS(WORD_BITS)) u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iv_ff),
      .in_bit    (pk_bit),
      .in_ready  (pk_ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (rsp.mask_word),
      .out_count (rsp.valid_bits),
      .out_final (rsp.final_word)
   );

   // a stalled word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.mask_word)
         && $stable(rsp.valid_bits))
      else $error("rsp word changed while stalled");

   // a pending item is not dropped while the packer stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      iv_ff && !pk_ready |=> iv_ff && $stable(int_ff) && $stable(flt_ff))
      else $error("input register lost a stalled item");

   // word count is never zero or above the word size
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.valid_bits != 7'd0 && rsp.valid_bits <= 7'(WORD_BITS))
      else $error("bad valid_bits");
endmodule

// ===== dv/tb_checker.sv =====
// checker: predicts packed compare words from observed items and compares them
module tb_checker
   import ifcb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ifcb_req_if.monitor req_mon,
   ifcb_rsp_if.monitor rsp_mon,
   ifcb_csr_if.monitor csr_mon,
   output int         error_count,
   output int         words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] mask_word;
      logic [6:0]  valid_bits;
      logic        final_word;
   } word_type;

   word_type    word_queue[$];
   cfg_type     cfg;
   logic [63:0] open_bits;
   logic [6:0]  open_count;

   assign words_pending = word_queue.size();

   // sign extend from the configured width
   function automatic logic [63:0] widen(logic [63:0] raw, logic [1:0] code);
      case (code)
         W8:      return {{56{raw[7]}}, raw[7:0]};
         W16:     return {{48{raw[15]}}, raw[15:0]};
         W32:     return {{32{raw[31]}}, raw[31:0]};
         default: return raw;
      endcase
   endfunction

   // compare item against float under operator and operand order
   function automatic logic compare_item(logic [63:0] iv, logic [63:0] fb, cfg_type c);
      real a;
      real b;
      real x;
      real y;
      logic nan;
      a = real'($signed(iv));
      b = $bitstoreal(fb);
      nan = (fb[62:52] == 11'h7ff) && (fb[51:0] != 0);
      if (nan) return 1'b0;
      x = c.int_on_left ? a : b;
      y = c.int_on_left ? b : a;
      case (c.op)
         OP_EQ:   return x == y;
         OP_LT:   return x < y;
         default: return x > y;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg <= '{width_code: W64, int_on_left: 1'b1, op: OP_EQ};
         open_bits = '0;
         open_count = '0;
         word_queue.delete();
         error_count <= 0;
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_WIDTH: cfg.width_code <= csr_mon.data[1:0];
               REG_ORDER: cfg.int_on_left <= csr_mon.data[0];
               REG_OP:    cfg.op <= csr_mon.data[1:0];
               default: ;
            endcase
         end
         // accepted item: pack its bit
         if (req_mon.valid && req_mon.ready) begin
            if (compare_item(widen(req_mon.int_elem, cfg.width_code),
                  req_mon.float_bits, cfg))
               open_bits[open_count[5:0]] = 1'b1;
            open_count = open_count + 7'd1;
            if (open_count == 7'd64 || req_mon.last_item) begin
               word_queue.push_back('{open_bits, open_count, req_mon.last_item});
               open_bits = '0;
               open_count = '0;
            end
         end
         // accepted word: compare with oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (word_queue.size() == 0) begin
               $display("%0t: unexpected word mask=%h bits=%0d final=%b", $time,
                  rsp_mon.mask_word, rsp_mon.valid_bits, rsp_mon.final_word);
               error_count <= error_count + 1;
            end else begin
               if (word_queue[0].mask_word !== rsp_mon.mask_word
                     || word_queue[0].valid_bits !== rsp_mon.valid_bits
                     || word_queue[0].final_word !== rsp_mon.final_word) begin
                  $display("%0t: expected mask=%h bits=%0d final=%b, got mask=%h bits=%0d final=%b",
                     $time, word_queue[0].mask_word, word_queue[0].valid_bits,
                     word_queue[0].final_word, rsp_mon.mask_word,
                     rsp_mon.valid_bits, rsp_mon.final_word);
                  error_count <= error_count + 1;
               end
               void'(word_queue.pop_front());
            end
         end
      end
   end
endmodule

// ===== dv/tb.sv =====
// testbench top: stimulus, idling, pressure phases and verdict
module tb;
   import ifcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   words_pending;
   int   hold_cycles = 0;

   ifcb_req_if req_ch();
   ifcb_rsp_if rsp_ch();
   ifcb_csr_if csr_ch();

   int_float_compare_bitmask_packer u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr(csr_ch.sink));

   tb_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch.monitor),
      .rsp_mon(rsp_ch.monitor), .csr_mon(csr_ch.monitor),
      .error_count(error_count), .words_pending(words_pending));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.int_elem = '0;
      req_ch.float_bits = '0;
      req_ch.last_item = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_WIDTH;
      csr_ch.data = '0;
   end

   // send one item, with a random gap first; valid is lowered only for a gap
   task automatic send_item(logic [63:0] iv, logic [63:0] fb, logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.int_elem <= iv;
      req_ch.float_bits <= fb;
      req_ch.last_item <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // back-to-back item without lowering valid in between
   task automatic stream_item(logic [63:0] iv, logic [63:0] fb, logic last);
      req_ch.valid <= 1'b1;
      req_ch.int_elem <= iv;
      req_ch.float_bits <= fb;
      req_ch.last_item <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, then wait until all words are out, plus pipeline drain
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // float near the integer, or a random value, a nan or infinity, so that equality and ordering are exercised
   function automatic logic [63:0] pick_float(logic [63:0] iv, logic [1:0] code);
      logic [63:0] w;
      case (code)
         W8:      w = {{56{iv[7]}}, iv[7:0]};
         W16:     w = {{48{iv[15]}}, iv[15:0]};
         W32:     w = {{32{iv[31]}}, iv[31:0]};
         default: w = iv;
      endcase
      case ($urandom_range(0, 7))
         0:       return {$urandom, $urandom};
         1:       return {1'($urandom), 11'h7ff, 20'($urandom) | 20'd1, 32'($urandom)};
         2:       return 64'h7ff0_0000_0000_0000;
         3:       return $realtobits(real'($signed(w)) + 1.0);
         4:       return $realtobits(real'($signed(w)) - 1.0);
         default: return $realtobits(real'($signed(w)));
      endcase
   endfunction

   // receiver: random wait before each word plus one long hold-off
   initial begin
      int rsp_wait;
      rsp_wait = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_wait = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) rsp_wait = 0;
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      logic [63:0] iv;
      logic [1:0]  code;
      int          len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, special values, every operator
      code = W64;
      send_item(64'h7fff_ffff_ffff_ffff, 64'h43e0_0000_0000_0000, 1'b0);
      send_item(64'h8000_0000_0000_0000, 64'hc3e0_0000_0000_0000, 1'b0);
      send_item(64'h0020_0000_0000_0001, 64'h4340_0000_0000_0000, 1'b0);
      send_item(64'h0020_0000_0000_0003, 64'h4340_0000_0000_0002, 1'b0);
      send_item('0, 64'h8000_0000_0000_0000, 1'b0);
      send_item('0, 64'h7ff8_0000_0000_0000, 1'b0);
      send_item('1, 64'hfff0_0000_0000_0000, 1'b1);
      drain();
      for (int op = 0; op < 4; op++) begin
         write_reg(REG_OP, 64'(op));
         for (int ord = 0; ord < 2; ord++) begin
            write_reg(REG_ORDER, 64'(ord));
            send_item(64'd5, $realtobits(5.0), 1'b0);
            send_item(64'd5, $realtobits(6.0), 1'b0);
            send_item(64'd5, 64'hfff8_0000_0000_0001, 1'b1);
            drain();
         end
      end
      write_reg(REG_WIDTH, 64'(W8));
      send_item(64'hffff_ffff_ffff_ff80, $realtobits(-128.0), 1'b1);
      drain();

      // random arrays over random settings
      for (int arr = 0; arr < 40; arr++) begin
         code = 2'($urandom);
         write_reg(REG_WIDTH, 64'(code));
         write_reg(REG_ORDER, 64'($urandom_range(0, 1)));
         write_reg(REG_OP, 64'($urandom_range(0, 3)));
         if (arr == 8) len = 64;
         else len = (arr % 8 == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
         // one array with a long receiver stall and back-to-back items
         if (arr == 5) begin
            hold_cycles = 150;
            for (int k = 0; k < 130; k++) begin
               iv = {$urandom, $urandom};
               stream_item(iv, pick_float(iv, code), k == 129);
            end
         end else begin
            for (int k = 0; k < len; k++) begin
               iv = {$urandom, $urandom};
               if ($urandom_range(0, 9) == 0) iv = $urandom_range(0, 1) ? '1 : '0;
               send_item(iv, pick_float(iv, code), k == len - 1);
            end
         end
         drain();
      end
      if (error_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/ifcb_pkg.sv
rtl/ifcb_if.sv
rtl/ifcb_cmp.sv
rtl/ifcb_pack.sv
rtl/int_float_compare_bitmask_packer.sv
dv/tb_checker.sv
dv/tb.sv
